// ----- hdl/lfp_pkg.sv -----
// Package for the LIFO free index pool: request, status, cell and state codes.
// Used by lfp_cell, the core top level, the port checker and the testbench; depends on nothing.
package lfp_pkg;

  localparam int IDX_W    = 6;   // entry index field width
  localparam int SIZE_W   = 7;   // pool size register width
  localparam int POOL_RST = 64;  // pool size after reset

  typedef enum logic [1:0] {
    REQ_ACQUIRE,
    REQ_RELEASE,
    REQ_EXPIRE,
    REQ_NONE
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_EMPTY,
    STAT_RANGE,
    STAT_FULL
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_EXPIRE,
    CELL_INIT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SETTLE,
    ST_RESP
  } state_t;

  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      exp_idx;
    logic [SIZE_W-1:0]     init_size;
  } lfp_ctl_t;

endpackage

// ----- hdl/lifo_free_index_pool_with_expiry_core.sv -----
// Top level of the LIFO free index pool with entry expiry.
// Each input word passes through the response state into the output register. Release,
// ignored and unused requests go there directly; acquire first pops slots (one live grant plus
// dead ones, or all of them when the stack runs dry); expire first waits out the summary ripple.
// One word is in work at a time; the next is taken while the result waits in the output register.
// Reset (synchronous, rst_n low) reloads a pool of 64 at once; no clearing pass is needed.
module lifo_free_index_pool_with_expiry_core
  import lfp_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [IDX_W-1:0]  in_entry_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [IDX_W-1:0]  out_granted_index,
  output logic              out_any_available,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_pool_size
);

  // The pool size register is 7 bits, so no pushed index ever exceeds 126.
  // Stored indices and the alive flags only need to cover that many entries.
  localparam int EFF_MAX = (MAX_ENTRIES < 128) ? MAX_ENTRIES : 128;
  localparam int VW      = $clog2(EFF_MAX);
  localparam int CW      = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW    = (CW > IDX_W) ? CW : IDX_W;
  localparam int RST_EFF = (MAX_ENTRIES < POOL_RST) ? MAX_ENTRIES : POOL_RST;

  function automatic logic [CW-1:0] eff_of(input logic [SIZE_W-1:0] s);
    if (int'(s) > MAX_ENTRIES) eff_of = CW'(MAX_ENTRIES);
    else eff_of = CW'(s);
  endfunction

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   pool_size_r, pool_size_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       wait_r, wait_nxt;
  status_t             status_r, status_nxt;
  logic [VW-1:0]       grant_r, grant_nxt;
  logic [EFF_MAX-1:0]  alive_r, alive_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [IDX_W-1:0]    out_grant_r, out_grant_nxt;
  logic                out_any_r, out_any_nxt;

  lfp_ctl_t            ctl;
  logic                in_accept, cfg_accept, out_free;
  logic [CW-1:0]       eff_size;
  logic                range_bad;
  logic [VW-1:0]       aidx;
  logic                push_live;

  // Cell chain: cell 0 is the top of the stack.
  logic [VW-1:0]       cval  [MAX_ENTRIES];
  logic                clive [MAX_ENTRIES];
  logic                cocc  [MAX_ENTRIES];
  logic                csum  [MAX_ENTRIES];

  // Configuration wins a tie with an input word; both are only taken while idle.
  assign cfg_ready  = (state_r == ST_IDLE);
  assign in_ready   = (state_r == ST_IDLE) && !cfg_valid;
  assign in_accept  = in_valid && in_ready;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign out_free   = !out_valid_r || out_ready;

  assign eff_size  = eff_of(pool_size_r);
  assign range_bad = (CMPW'(in_entry_index) >= CMPW'(eff_size));
  assign aidx      = VW'(in_entry_index);
  assign push_live = alive_r[aidx];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (req_t'(in_req_type))
            REQ_ACQUIRE: state_nxt = ST_POP;
            REQ_EXPIRE:  state_nxt = range_bad ? ST_RESP : ST_SETTLE;
            default:     state_nxt = ST_RESP;
          endcase
        end
      end
      ST_POP: begin
        if ((count_r == '0) || clive[0]) state_nxt = ST_RESP;
      end
      ST_SETTLE: begin
        if (wait_r == '0) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and cell control.
  always_comb begin
    ctl.op         = CELL_HOLD;
    ctl.exp_idx    = in_entry_index;
    ctl.init_size  = SIZE_W'(eff_of(cfg_pool_size));
    pool_size_nxt  = pool_size_r;
    count_nxt      = count_r;
    wait_nxt       = wait_r;
    status_nxt     = status_r;
    grant_nxt      = grant_r;
    alive_nxt      = alive_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    out_any_nxt    = out_any_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_accept) begin
          // A new size reloads the whole stack and revives every entry.
          pool_size_nxt = cfg_pool_size;
          count_nxt     = eff_of(cfg_pool_size);
          alive_nxt     = '1;
          ctl.op        = CELL_INIT;
        end else if (in_accept) begin
          status_nxt = STAT_OK;
          grant_nxt  = '0;
          case (req_t'(in_req_type))
            REQ_ACQUIRE: begin
              status_nxt = STAT_EMPTY;
            end
            REQ_RELEASE: begin
              if (range_bad) begin
                status_nxt = STAT_RANGE;
              end else if (count_r == CW'(MAX_ENTRIES)) begin
                status_nxt = STAT_FULL;
              end else begin
                ctl.op    = CELL_PUSH;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_EXPIRE: begin
              if (range_bad) begin
                status_nxt = STAT_RANGE;
              end else begin
                // Every stacked copy of the index loses its alive flag; the
                // summaries then ripple up while the settle state waits for them.
                ctl.op          = CELL_EXPIRE;
                alive_nxt[aidx] = 1'b0;
                wait_nxt        = count_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        // One slot leaves the top per cycle; dead indices are dropped for good.
        if (count_r != '0) begin
          ctl.op    = CELL_POP;
          count_nxt = count_r - CW'(1);
          if (clive[0]) begin
            status_nxt = STAT_OK;
            grant_nxt  = cval[0];
          end
        end
      end
      ST_SETTLE: begin
        if (wait_r != '0) wait_nxt = wait_r - CW'(1);
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_grant_nxt  = IDX_W'(grant_r);
          out_any_nxt    = csum[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pool_size_r <= SIZE_W'(POOL_RST);
      count_r     <= CW'(RST_EFF);
      wait_r      <= '0;
      alive_r     <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_size_r <= pool_size_nxt;
      count_r     <= count_nxt;
      wait_r      <= wait_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    grant_r      <= grant_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_any_r    <= out_any_nxt;
  end

  // The stack itself: a row of cells that shift down on push and up on pop.
  // The summary bit of cell i tells whether any occupied cell at i or deeper
  // holds a live index, so cell 0 gives the availability flag directly.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [VW-1:0] up_val, dn_val;
    logic          up_live, up_occ, up_sum, dn_live, dn_occ, dn_sum;

    if (i == 0) begin : g_top
      assign up_val  = aidx;
      assign up_live = push_live;
      assign up_occ  = 1'b1;
      assign up_sum  = push_live | csum[0];
    end else begin : g_mid
      assign up_val  = cval[i-1];
      assign up_live = clive[i-1];
      assign up_occ  = cocc[i-1];
      assign up_sum  = csum[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_bot
      assign dn_val  = '0;
      assign dn_live = 1'b0;
      assign dn_occ  = 1'b0;
      assign dn_sum  = 1'b0;
    end else begin : g_up
      assign dn_val  = cval[i+1];
      assign dn_live = clive[i+1];
      assign dn_occ  = cocc[i+1];
      assign dn_sum  = csum[i+1];
    end

    lfp_cell #(
      .VW       (VW),
      .POS      (i),
      .RST_SIZE (RST_EFF)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .up_val  (up_val),
      .up_live (up_live),
      .up_occ  (up_occ),
      .up_sum  (up_sum),
      .dn_val  (dn_val),
      .dn_live (dn_live),
      .dn_occ  (dn_occ),
      .dn_sum  (dn_sum),
      .val     (cval[i]),
      .live    (clive[i]),
      .occ     (cocc[i]),
      .sum     (csum[i])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_grant_r;
  assign out_any_available = out_any_r;

endmodule

// ----- hdl/lfp_cell.sv -----
// One slot of the shifting free-index stack: index, alive flag, occupancy and
// an "alive at or below" summary. Depends on lfp_pkg.
module lfp_cell
  import lfp_pkg::*;
#(
  parameter int VW       = 6,
  parameter int POS      = 0,
  parameter int RST_SIZE = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lfp_ctl_t      ctl,
  input  logic [VW-1:0] up_val,
  input  logic          up_live,
  input  logic          up_occ,
  input  logic          up_sum,
  input  logic [VW-1:0] dn_val,
  input  logic          dn_live,
  input  logic          dn_occ,
  input  logic          dn_sum,
  output logic [VW-1:0] val,
  output logic          live,
  output logic          occ,
  output logic          sum
);

  localparam logic RST_OCC = (POS < RST_SIZE);
  localparam logic [VW-1:0] RST_VAL = (POS < RST_SIZE) ? VW'(RST_SIZE - 1 - POS) : '0;

  logic [VW-1:0] val_r, val_nxt;
  logic          live_r, live_nxt;
  logic          occ_r, occ_nxt;
  logic          sum_r, sum_nxt;
  logic          init_occ;

  assign init_occ = (POS < int'(ctl.init_size));

  always_comb begin
    val_nxt  = val_r;
    live_nxt = live_r;
    occ_nxt  = occ_r;
    sum_nxt  = (live_r & occ_r) | dn_sum;
    case (ctl.op)
      CELL_PUSH: begin
        val_nxt  = up_val;
        live_nxt = up_live;
        occ_nxt  = up_occ;
        sum_nxt  = up_sum;
      end
      CELL_POP: begin
        val_nxt  = dn_val;
        live_nxt = dn_live;
        occ_nxt  = dn_occ;
        sum_nxt  = dn_sum;
      end
      CELL_EXPIRE: begin
        live_nxt = live_r & (val_r != VW'(ctl.exp_idx));
      end
      CELL_INIT: begin
        occ_nxt  = init_occ;
        live_nxt = 1'b1;
        sum_nxt  = init_occ;
        val_nxt  = init_occ ? VW'(ctl.init_size - SIZE_W'(POS) - SIZE_W'(1)) : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r  <= RST_VAL;
      live_r <= 1'b1;
      occ_r  <= RST_OCC;
      sum_r  <= RST_OCC;
    end else begin
      val_r  <= val_nxt;
      live_r <= live_nxt;
      occ_r  <= occ_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign val  = val_r;
  assign live = live_r;
  assign occ  = occ_r;
  assign sum  = sum_r;

endmodule

// ----- hdl/lfp_checker.sv -----
// Port-level checker for the LIFO free index pool core, with its bind statement.
// Depends on lfp_pkg and on the core's port names.
module lfp_checker
  import lfp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic [IDX_W-1:0]  out_granted_index,
  input logic              out_any_available
);

  // Only one word is in work, so in_ready is low in the cycle after a word is accepted.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in work");

  // Only a successful acquire carries a granted index.
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_granted_index == '0))
    else $error("granted index nonzero on a failed request");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_granted_index) && $stable(out_any_available))
    else $error("result word changed while stalled");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lifo_free_index_pool_with_expiry_core lfp_checker u_lfp_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lifo_free_index_pool_with_expiry_core: a scoreboard class
// predicts each result word; tasks drive requests and pool size writes. Needs lfp_pkg.
module testbench;
  import lfp_pkg::*;

  localparam int POOL_DEPTH  = 64;    // pool capacity of the block under test
  localparam int RAND_PHASES = 10;    // random phases, each under its own pool size
  localparam int PHASE_WORDS = 200;   // request words per random phase
  localparam int HOLD_CYCLES = 400;   // the one long receiver hold-off
  localparam int STALL_LIMIT = 4000;  // cycles without any handshake before giving up
  localparam int DRAIN_WAIT  = 80;    // idle wait after the last result word, before the summary

  // One expected result word.
  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] granted;
    logic             avail;
  } pool_resp_t;

  // The scoreboard keeps its own image of the free-index stack and of the per-entry
  // live flags. Each accepted request updates that image and queues the result word
  // the block must return; each returned word is checked against the oldest one queued.
  class pool_scoreboard;
    logic [IDX_W-1:0] free_ids [POOL_DEPTH];
    bit               live_flag [POOL_DEPTH];
    int unsigned      depth;
    int unsigned      active_size;
    pool_resp_t       expected_responses [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      status_seen [4];

    function new();
      errors  = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      load_size(POOL_RST);
    endfunction

    // A pool size write (or reset) restacks 0 .. size-1 with size-1 on top and revives
    // every entry. Sizes past the capacity are clamped to it.
    function void load_size(int unsigned size);
      int i;
      active_size = (size > POOL_DEPTH) ? POOL_DEPTH : size;
      for (i = 0; i < POOL_DEPTH; i++) begin
        free_ids[i]  = (i < active_size) ? IDX_W'(i) : '0;
        live_flag[i] = 1'b1;
      end
      depth = active_size;
    endfunction

    function bit live_on_stack();
      int i;
      for (i = 0; i < depth; i++)
        if (live_flag[free_ids[i]]) return 1'b1;
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] req, logic [IDX_W-1:0] idx);
      pool_resp_t       resp;
      logic [IDX_W-1:0] top;
      resp.status  = STAT_OK;
      resp.granted = '0;
      case (req)
        REQ_ACQUIRE: begin
          // Dead entries popped on the way down are gone from the stack for good.
          resp.status = STAT_EMPTY;
          while (depth > 0 && resp.status == STAT_EMPTY) begin
            depth--;
            top = free_ids[depth];
            if (live_flag[top]) begin
              resp.status  = STAT_OK;
              resp.granted = top;
            end
          end
        end
        REQ_RELEASE: begin
          // The range check wins over the full check; duplicates are pushed as is.
          if (idx >= active_size) begin
            resp.status = STAT_RANGE;
          end else if (depth >= POOL_DEPTH) begin
            resp.status = STAT_FULL;
          end else begin
            free_ids[depth] = idx;
            depth++;
          end
        end
        REQ_EXPIRE: begin
          if (idx >= active_size) resp.status = STAT_RANGE;
          else live_flag[idx] = 1'b0;
        end
        default: ;
      endcase
      resp.avail = live_on_stack();
      expected_responses.push_back(resp);
    endfunction

    function void check_response(logic [1:0] status, logic [IDX_W-1:0] granted, logic avail);
      pool_resp_t want;
      if (expected_responses.size() == 0) begin
        $error("result word with no request outstanding: status %0d granted %0d available %0b",
               status, granted, avail);
        errors++;
        return;
      end
      want = expected_responses.pop_front();
      checked++;
      status_seen[want.status]++;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (granted !== want.granted) begin
        $error("granted_index: expected %0d, got %0d", want.granted, granted);
        errors++;
      end
      if (avail !== want.avail) begin
        $error("any_available: expected %0b, got %0b", want.avail, avail);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_responses.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_req_type;
  logic [IDX_W-1:0]  in_entry_index;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [IDX_W-1:0]  out_granted_index;
  logic              out_any_available;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_pool_size;

  pool_scoreboard sb = new();

  bit          hold_request = 1'b0;  // main flow asks the receiver for the long hold-off
  int unsigned burst_left   = 0;     // words left in the sender's current burst
  int unsigned sizes_loaded = 0;

  lifo_free_index_pool_with_expiry_core #(
    .MAX_ENTRIES(POOL_DEPTH)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_any_available (out_any_available),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_pool_size     (cfg_pool_size)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // All handshakes are observed at the rising edge, where the block sees them too.
  // A pool size write, a request and a result word never belong to the same request,
  // so the order of the three calls below does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.load_size(cfg_pool_size);
      if (in_valid && in_ready) sb.note_request(in_req_type, in_entry_index);
      if (out_valid && out_ready) sb.check_response(out_status, out_granted_index,
                                                    out_any_available);
    end
  end

  // Receiver: stretches of random length, each with a stall pattern of its own (always
  // ready, coin flip, mostly stalled, or three in four). On request it holds off once
  // for a long stretch so that the output register and then the input side back up.
  initial begin : receiver
    int          mode;
    int          span;
    int unsigned tick;
    out_ready = 1'b0;
    tick      = 0;
    forever begin
      if (hold_request) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = 1'($urandom_range(0, 1));
          2:       out_ready = ($urandom_range(0, 4) == 0);
          default: out_ready = (tick % 4 != 3);
        endcase
      end
    end
  end

  // Watchdog: any handshake on any channel restarts the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timed out after %0d cycles without a handshake.", STALL_LIMIT);
    $display("lifo_free_index_pool_with_expiry_core verification failed");
    $finish;
  end

  // Offers one request word. The sender works in bursts: at the start of each burst it
  // may drop valid for a random gap. Valid stays high between words of a burst. Called
  // and returning at a falling edge.
  task automatic send_word(input logic [1:0] req, input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       = 1'b1;
    in_req_type    = req;
    in_entry_index = idx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Pool size writes go in only once every result word is back and the block has had
  // time to settle.
  task automatic write_pool_size(input logic [SIZE_W-1:0] size);
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid     = 1'b1;
    cfg_pool_size = size;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    sizes_loaded++;
  endtask

  // One random request. Most indexes fall inside the pool so that releases and expires
  // really act on it; the rest are drawn over the whole field to hit the range check.
  task automatic send_random_word(input int acq_pct, input int rel_pct);
    int               roll;
    logic [1:0]       req;
    logic [IDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    if (roll < acq_pct)                  req = REQ_ACQUIRE;
    else if (roll < acq_pct + rel_pct)   req = REQ_RELEASE;
    else if ($urandom_range(0, 9) != 0)  req = REQ_EXPIRE;
    else                                 req = REQ_NONE;
    if ($urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, sb.active_size - 1));
    else                            idx = IDX_W'($urandom_range(0, POOL_DEPTH - 1));
    send_word(req, idx);
  endtask

  initial begin : main_flow
    int          ph;
    int          n;
    int          acq_pct;
    int          rel_pct;
    int unsigned size;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_ACQUIRE;
    in_entry_index = '0;
    cfg_valid      = 1'b0;
    cfg_pool_size  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, starting from the full pool of 64 that reset leaves.
    // A release onto a full stack is dropped, at both ends of the index range.
    send_word(REQ_RELEASE, 6'd0);
    send_word(REQ_RELEASE, 6'd63);
    send_word(REQ_ACQUIRE, '0);
    // Expire the entry now on top, so the next acquire skips over it.
    send_word(REQ_EXPIRE, 6'd62);
    send_word(REQ_ACQUIRE, '0);
    // A duplicate release is pushed twice; once dead, both copies are skipped.
    send_word(REQ_RELEASE, 6'd63);
    send_word(REQ_RELEASE, 6'd63);
    send_word(REQ_EXPIRE, 6'd63);
    send_word(REQ_ACQUIRE, '0);
    // A dead entry is still pushed on release, and expiring it again changes nothing.
    send_word(REQ_RELEASE, 6'd62);
    send_word(REQ_EXPIRE, 6'd62);
    // The unused request code leaves the pool alone.
    send_word(REQ_NONE, 6'd63);
    send_word(REQ_EXPIRE, 6'd0);

    // A pool of five: range checks above it, then drain it past empty.
    write_pool_size(7'd5);
    send_word(REQ_RELEASE, 6'd5);
    send_word(REQ_EXPIRE, 6'd63);
    repeat (6) send_word(REQ_ACQUIRE, '0);

    // An empty pool: every index is out of range and acquire finds nothing.
    write_pool_size(7'd0);
    send_word(REQ_ACQUIRE, '0);
    send_word(REQ_RELEASE, 6'd0);
    send_word(REQ_EXPIRE, 6'd0);

    // The largest register value clamps to the capacity, so the stack starts full.
    write_pool_size(7'd127);
    send_word(REQ_RELEASE, 6'd63);

    // Random part. Each phase loads a pool size (the extremes first, then mostly small
    // pools, where empty and full stacks are frequent) and draws its own request mix,
    // from acquire-heavy draining to release-heavy filling.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       size = 1;
        1:       size = 64;
        2:       size = 127;
        3:       size = 2;
        default: size = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 127);
      endcase
      write_pool_size(SIZE_W'(size));
      acq_pct = $urandom_range(15, 55);
      rel_pct = $urandom_range(15, 55);
      // The long hold-off falls inside a phase, while requests keep coming.
      if (ph == 1) hold_request = 1'b1;
      for (n = 0; n < PHASE_WORDS; n++) send_random_word(acq_pct, rel_pct);
    end

    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Checked %0d result words under %0d pool size writes",
             sb.checked, sizes_loaded);
    $display("(sizes 0, 1, 64, 127 among them). Results by status: ok %0d, empty %0d,",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY]);
    $display("out of range %0d, stack full %0d.",
             sb.status_seen[STAT_RANGE], sb.status_seen[STAT_FULL]);
    if (sb.errors == 0) begin
      $display("lifo_free_index_pool_with_expiry_core verification clean");
    end else begin
      $display("lifo_free_index_pool_with_expiry_core verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lfp_pkg.sv
hdl/lfp_cell.sv
hdl/lifo_free_index_pool_with_expiry_core.sv
hdl/lfp_checker.sv
test/testbench.sv
